// ----- hdl/smp_pkg.sv -----
// Shared constants, types and default sizes for the segment mean pooling block.
package smp_pkg;

  // Fixed field widths
  localparam int FEAT_W      = 16;
  localparam int NUM_FEAT    = 4;
  localparam int COUNT_OUT_W = 17;
  localparam int LIMIT_W     = 9;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  // Quotient bits: a mean of 16 bit values needs at most 17 magnitude bits
  localparam int QUOT_W = FEAT_W + 1;

  // Default sizes
  localparam int MAX_SEGMENTS_DEF = 256;
  localparam int CHANNELS_DEF     = 4;
  localparam int MAX_PIXELS_DEF   = 65536;

  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_DIV
  } state_e;

endpackage

// ----- hdl/segment_mean_pooling_top.sv -----
// Segment mean pooling: per-segment feature sums and pixel counts, read back as means.
//
// Accumulate transactions are taken one per clock while the block runs and no read
// sits in stage 1: each reads its segment's row from a single RAM (registered
// read) and writes the updated row back in the next cycle, with the last write
// forwarded so back-to-back hits on one segment are exact. A read transaction
// passes through the RAM read, the one-bit-per-cycle divider shared by all
// channels and the load of the result register; no further transaction is taken
// until the result is loaded, though accumulation carries on while a finished
// result waits on the output. After reset the block sweeps the whole RAM to
// zero, one segment a cycle, before taking its first transaction; the limit
// register may be written at any time.
module segment_mean_pooling_top #(
  parameter int MAX_SEGMENTS = smp_pkg::MAX_SEGMENTS_DEF,
  parameter int CHANNELS     = smp_pkg::CHANNELS_DEF,
  parameter int MAX_PIXELS   = smp_pkg::MAX_PIXELS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // input channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   op_i,
  input  logic signed [smp_pkg::FEAT_W-1:0]      segment_label_i,
  input  logic signed [smp_pkg::FEAT_W-1:0]      feature_0_i,
  input  logic signed [smp_pkg::FEAT_W-1:0]      feature_1_i,
  input  logic signed [smp_pkg::FEAT_W-1:0]      feature_2_i,
  input  logic signed [smp_pkg::FEAT_W-1:0]      feature_3_i,
  // output channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [smp_pkg::FEAT_W-1:0]      mean_0_o,
  output logic signed [smp_pkg::FEAT_W-1:0]      mean_1_o,
  output logic signed [smp_pkg::FEAT_W-1:0]      mean_2_o,
  output logic signed [smp_pkg::FEAT_W-1:0]      mean_3_o,
  output logic [smp_pkg::COUNT_OUT_W-1:0]        pixel_count_o,
  // configuration
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [smp_pkg::LIMIT_W-1:0]            cfg_data_i
);

  localparam int FW     = smp_pkg::FEAT_W;
  localparam int NF     = smp_pkg::NUM_FEAT;
  localparam int SEG_AW = $clog2(MAX_SEGMENTS);
  localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int SUM_W  = FW + 1 + $clog2(MAX_PIXELS);
  localparam int ROW_W  = CNT_W + CHANNELS * SUM_W;

  smp_pkg::state_e state_q, state_d;

  logic [smp_pkg::LIMIT_W-1:0]     limit_q;
  logic [SEG_AW-1:0]               clr_idx_q;

  // input decode
  logic                            in_accept;
  logic [FW-2:0]                   lab_mag;
  logic                            label_ok;
  logic [SEG_AW-1:0]               lab_addr;
  logic [NF-1:0][FW-1:0]           feat_in;

  // stage 1: item whose row is being read
  logic                            s1_valid_q;
  smp_pkg::op_e                    s1_op_q;
  logic                            s1_ok_q;
  logic [SEG_AW-1:0]               s1_addr_q;
  logic [CHANNELS-1:0][FW-1:0]     s1_feat_q;
  logic                            s1_read;

  // RAM and forwarding
  logic                            ram_we;
  logic [SEG_AW-1:0]               ram_waddr;
  logic [ROW_W-1:0]                ram_wdata;
  logic [ROW_W-1:0]                ram_rdata;
  logic                            fwd_valid_q;
  logic [SEG_AW-1:0]               fwd_addr_q;
  logic [ROW_W-1:0]                fwd_row_q;
  logic [ROW_W-1:0]                row_cur;
  logic [CNT_W-1:0]                cur_cnt;
  logic [CHANNELS-1:0][SUM_W-1:0]  cur_sums;
  logic [CHANNELS-1:0][SUM_W-1:0]  new_sums;

  // divider and result
  logic                            div_busy;
  logic [CHANNELS-1:0][SUM_W-1:0]  div_sums;
  logic [CNT_W-1:0]                div_cnt;
  logic [CHANNELS-1:0][FW-1:0]     div_quot;
  logic [CNT_W-1:0]                rd_cnt_q;
  logic                            out_free;
  logic                            out_load;
  logic                            out_valid_q;
  logic [NF-1:0][FW-1:0]           out_mean_q;
  logic [NF-1:0][FW-1:0]           mean_nxt;
  logic [CNT_W-1:0]                out_cnt_q;

  // Configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= smp_pkg::LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  // Label check against both the register and the capacity
  assign lab_mag  = segment_label_i[FW-2:0];
  assign label_ok = !segment_label_i[FW-1]
                    && (32'(lab_mag) < 32'(limit_q))
                    && (32'(lab_mag) < 32'(MAX_SEGMENTS));
  assign lab_addr = lab_mag[SEG_AW-1:0];
  assign feat_in  = {feature_3_i, feature_2_i, feature_1_i, feature_0_i};

  assign s1_read    = s1_valid_q && (s1_op_q == smp_pkg::OP_READ);
  assign in_stall_o = (state_q != smp_pkg::ST_RUN) || s1_read;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Stage 1 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q   <= smp_pkg::op_e'(op_i);
      s1_ok_q   <= label_ok;
      s1_addr_q <= label_ok ? lab_addr : '0;
      s1_feat_q <= feat_in[CHANNELS-1:0];
    end
  end

  // Row store: {count, channel sums}
  smp_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (lab_addr),
    .rdata_o (ram_rdata)
  );

  // Forward the write of the previous edge, which the RAM read missed
  assign row_cur  = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_row_q : ram_rdata;
  assign cur_cnt  = row_cur[ROW_W-1 -: CNT_W];
  assign cur_sums = row_cur[CHANNELS*SUM_W-1:0];

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      new_sums[c] = cur_sums[c] + {{(SUM_W-FW){s1_feat_q[c][FW-1]}}, s1_feat_q[c]};
    end
  end

  // Write-back: clearing sweep, accumulate update (none once the count is at MAX_PIXELS), or clear on read
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = s1_addr_q;
    ram_wdata = '0;
    if (state_q == smp_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_q;
    end else if (s1_valid_q && s1_ok_q) begin
      if (s1_op_q == smp_pkg::OP_ACCUM) begin
        if (cur_cnt < CNT_W'(MAX_PIXELS)) begin
          ram_we    = 1'b1;
          ram_wdata = {cur_cnt + CNT_W'(1), new_sums};
        end
      end else begin
        ram_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= ram_we;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= ram_waddr;
    fwd_row_q  <= ram_wdata;
  end

  // Clearing sweep index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (state_q == smp_pkg::ST_CLEAR) begin
      clr_idx_q <= clr_idx_q + SEG_AW'(1);
    end
  end

  // Divider operands; an invalid label reads as an empty segment
  assign div_sums = s1_ok_q ? cur_sums : '0;
  assign div_cnt  = s1_ok_q ? cur_cnt : '0;

  smp_div #(
    .LANES (CHANNELS),
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (s1_read),
    .sum_i   (div_sums),
    .count_i (div_cnt),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (s1_read) begin
      rd_cnt_q <= div_cnt;
    end
  end

  // Control state machine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smp_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      smp_pkg::ST_CLEAR: begin
        if (clr_idx_q == SEG_AW'(MAX_SEGMENTS - 1)) begin
          state_d = smp_pkg::ST_RUN;
        end
      end
      smp_pkg::ST_RUN: begin
        if (s1_read) begin
          state_d = smp_pkg::ST_DIV;
        end
      end
      smp_pkg::ST_DIV: begin
        if (!div_busy && out_free) begin
          out_load = 1'b1;
          state_d  = smp_pkg::ST_RUN;
        end
      end
      default: begin
        state_d = smp_pkg::ST_CLEAR;
      end
    endcase
  end

  // Result register; unused channels read as zero
  always_comb begin
    mean_nxt = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      mean_nxt[c] = div_quot[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_mean_q <= mean_nxt;
      out_cnt_q  <= rd_cnt_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign mean_0_o      = out_mean_q[0];
  assign mean_1_o      = out_mean_q[1];
  assign mean_2_o      = out_mean_q[2];
  assign mean_3_o      = out_mean_q[3];
  assign pixel_count_o = smp_pkg::COUNT_OUT_W'(out_cnt_q);

  // Checks
  a_no_accept_during_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_read |-> !in_accept)
    else $error("transaction accepted while a read is in stage 1");

  a_read_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_read |=> (div_busy && state_q == smp_pkg::ST_DIV))
    else $error("read did not start the divider");

  a_no_write_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == smp_pkg::ST_DIV) |-> !ram_we)
    else $error("row RAM written while dividing");

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == smp_pkg::ST_CLEAR) |-> (!out_valid_q && !s1_valid_q))
    else $error("activity during the clearing sweep");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_cnt_q <= CNT_W'(MAX_PIXELS)))
    else $error("pixel count above capacity");

endmodule

// ----- hdl/smp_ram.sv -----
// Generic simple dual-port RAM with registered read (read-first on collision).
module smp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/smp_div.sv -----
// Multi-lane restoring divider: signed sums by an unsigned count, one bit a cycle.
module smp_div #(
  parameter int LANES = smp_pkg::CHANNELS_DEF,
  parameter int SUM_W = 33,
  parameter int CNT_W = 17
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [LANES-1:0][SUM_W-1:0]            sum_i,
  input  logic [CNT_W-1:0]                       count_i,
  output logic                                   busy_o,
  output logic [LANES-1:0][smp_pkg::FEAT_W-1:0]  quot_o
);

  localparam int QW     = smp_pkg::QUOT_W;
  localparam int STEP_W = $clog2(QW);

  logic                          busy_q;
  logic [STEP_W-1:0]             step_q;
  logic [CNT_W-1:0]              div_q;
  logic                          zero_q;
  logic [LANES-1:0]              neg_q;
  logic [LANES-1:0][CNT_W-1:0]   rem_q;
  logic [LANES-1:0][QW-1:0]      qs_q;

  logic [LANES-1:0][SUM_W-1:0]   mag;
  logic [LANES-1:0][CNT_W-1:0]   rem_init;
  logic [LANES-1:0][CNT_W:0]     trial;
  logic [LANES-1:0]              ge;
  logic [LANES-1:0][CNT_W-1:0]   rem_nxt;
  logic [LANES-1:0][QW-1:0]      q_signed;

  // Operand magnitudes and one restoring step per lane
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag[l]      = sum_i[l][SUM_W-1] ? (~sum_i[l] + SUM_W'(1)) : sum_i[l];
      rem_init[l] = CNT_W'(mag[l] >> QW);
      trial[l]    = {rem_q[l], qs_q[l][QW-1]};
      ge[l]       = trial[l] >= {1'b0, div_q};
      rem_nxt[l]  = ge[l] ? CNT_W'(trial[l] - {1'b0, div_q}) : CNT_W'(trial[l]);
      q_signed[l] = neg_q[l] ? (~qs_q[l] + QW'(1)) : qs_q[l];
      quot_o[l]   = zero_q ? '0 : q_signed[l][smp_pkg::FEAT_W-1:0];
    end
  end

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      if (step_q == STEP_W'(QW - 1)) begin
        busy_q <= 1'b0;
      end
      step_q <= step_q + STEP_W'(1);
    end
  end

  // Lane datapath; quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q  <= count_i;
      zero_q <= (count_i == '0);
      for (int l = 0; l < LANES; l++) begin
        neg_q[l] <= sum_i[l][SUM_W-1];
        rem_q[l] <= rem_init[l];
        qs_q[l]  <= mag[l][QW-1:0];
      end
    end else if (busy_q) begin
      for (int l = 0; l < LANES; l++) begin
        rem_q[l] <= rem_nxt[l];
        qs_q[l]  <= {qs_q[l][QW-2:0], ge[l]};
      end
    end
  end

  assign busy_o = busy_q;

endmodule
